/* src/mcdt_pkg.sv */
// ----------------------------------------------------------------------------
// mcdt_pkg
// Shared types and constants for the station address cooldown table.
// ----------------------------------------------------------------------------
package mcdt_pkg;

  localparam int ADDR_W = 48;
  localparam int TIME_W = 32;
  localparam int SLOTS_DEF = 8;
  localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd5000;

  // controller states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic start;   // item accepted, load it and clear the scan flags
    logic scan;    // compare the slot read this cycle
    logic commit;  // update the table and load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;      // the slot compared this cycle is the last one
    logic out_free;  // result register can take a new item
  } status_t;

endpackage

/* src/mcdt_ram.sv */
// ----------------------------------------------------------------------------
// mcdt_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mcdt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/mcdt_ctrl.sv */
// ----------------------------------------------------------------------------
// mcdt_ctrl
// Sequencer: accept an item, scan the slots, then commit the update.
// ----------------------------------------------------------------------------
module mcdt_ctrl
  import mcdt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // commands
  assign in_ready   = (state == ST_IDLE);
  assign cmd.start  = in_ready && in_valid;
  assign cmd.scan   = (state == ST_SCAN);
  assign cmd.commit = (state == ST_DONE) && status.out_free;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* src/mcdt_dp.sv */
// ----------------------------------------------------------------------------
// mcdt_dp
// Datapath: slot tables, one-slot-a-cycle match and victim search, result
// register and window register.
// ----------------------------------------------------------------------------
module mcdt_dp
  import mcdt_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output status_t           status,
  input  logic [ADDR_W-1:0] station_addr,
  input  logic [TIME_W-1:0] timestamp_ms,
  input  logic              cfg_we,
  input  logic [TIME_W-1:0] cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              forward,
  output logic              was_known
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  logic [TIME_W-1:0] window;
  logic [ADDR_W-1:0] addr_q;
  logic [TIME_W-1:0] now_q;
  logic [SLOTS-1:0]  valid;
  logic [IDX_W-1:0]  scan_idx;
  logic [IDX_W-1:0]  rd_addr;
  logic [ADDR_W-1:0] rd_entry_addr;
  logic [TIME_W-1:0] rd_entry_time;

  logic              hit_found;
  logic [IDX_W-1:0]  hit_idx;
  logic [TIME_W-1:0] hit_time;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  logic              best_found;
  logic [IDX_W-1:0]  best_idx;
  logic [TIME_W-1:0] best_time;

  logic              slot_valid;
  logic              slot_match;
  logic [TIME_W-1:0] age;
  logic              cool;
  logic [IDX_W-1:0]  victim;
  logic [IDX_W-1:0]  wr_idx;
  logic              addr_we;
  logic              time_we;

  // cooldown window register
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RESET;
    end else if (cfg_we) begin
      window <= cfg_data;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      addr_q <= station_addr;
      now_q  <= timestamp_ms;
    end
  end

  // scan counter; read address runs one slot ahead of the compare
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      scan_idx <= '0;
    end else if (cmd.scan) begin
      scan_idx <= scan_idx + 1'b1;
    end
  end

  assign rd_addr = cmd.scan ? IDX_W'(scan_idx + 1'b1) : '0;

  // per-slot compare
  assign slot_valid = valid[scan_idx];
  assign slot_match = slot_valid && (rd_entry_addr == addr_q);

  // hit, last free slot and oldest valid slot (first wins ties)
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      best_found <= 1'b0;
    end else if (cmd.scan) begin
      if (slot_match && !hit_found) begin
        hit_found <= 1'b1;
        hit_idx   <= scan_idx;
        hit_time  <= rd_entry_time;
      end
      if (!slot_valid) begin
        free_found <= 1'b1;
        free_idx   <= scan_idx;
      end else if (!best_found || (rd_entry_time < best_time)) begin
        best_found <= 1'b1;
        best_idx   <= scan_idx;
        best_time  <= rd_entry_time;
      end
    end
  end

  assign status.last     = (scan_idx == LAST_IDX);
  assign status.out_free = !out_valid || out_ready;

  // update decision
  assign age     = now_q - hit_time;
  assign cool    = (age < window);
  assign victim  = free_found ? free_idx : best_idx;
  assign wr_idx  = hit_found ? hit_idx : victim;
  assign addr_we = cmd.commit && !hit_found;
  assign time_we = cmd.commit && (!hit_found || !cool);

  // valid marks
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (addr_we) begin
      valid[victim] <= 1'b1;
    end
  end

  // slot tables
  mcdt_ram #(
    .WIDTH(ADDR_W),
    .DEPTH(SLOTS)
  ) u_addr_ram (
    .clk  (clk),
    .we   (addr_we),
    .waddr(wr_idx),
    .wdata(addr_q),
    .raddr(rd_addr),
    .rdata(rd_entry_addr)
  );

  mcdt_ram #(
    .WIDTH(TIME_W),
    .DEPTH(SLOTS)
  ) u_time_ram (
    .clk  (clk),
    .we   (time_we),
    .waddr(wr_idx),
    .wdata(now_q),
    .raddr(rd_addr),
    .rdata(rd_entry_time)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      forward   <= !hit_found || !cool;
      was_known <= hit_found;
    end
  end

endmodule

/* src/mac_cooldown_dedup_table_top.sv */
// ----------------------------------------------------------------------------
// mac_cooldown_dedup_table_top
// Cooldown filter for station addresses over a small table of recent ones.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries station_addr and timestamp_ms.
//   Output channel (out_valid/out_ready) returns forward and was_known, one
//   result item per input item, in order.
//   cfg_we/cfg_data write the cooldown window in ms (reset value 5000); write
//   it only while no item is in flight.
//   Each item scans the table one slot per cycle through the registered read
//   port of the slot RAMs, then commits the update and loads the result
//   register. A new item is taken only after the previous one has been
//   committed.
//   The result sits in an output register; while the receiver stalls the block
//   still accepts and scans the next item and then waits to commit it until
//   the register is taken.
//   Reset (rst, synchronous) clears all valid marks, the handshake state and
//   restores the window; slot contents are not cleared.
// ----------------------------------------------------------------------------
module mac_cooldown_dedup_table_top
  import mcdt_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ADDR_W-1:0] station_addr,
  input  logic [TIME_W-1:0] timestamp_ms,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              forward,
  output logic              was_known,
  input  logic              cfg_we,
  input  logic [TIME_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  // sequencer
  mcdt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  // table and search datapath
  mcdt_dp #(
    .SLOTS(SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .station_addr(station_addr),
    .timestamp_ms(timestamp_ms),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .forward     (forward),
    .was_known   (was_known)
  );

endmodule
